>>> sv/mila_pkg.sv
// Shared types and constants for the mutex identifier allocator and lock bank.
package mila_pkg;

  // Bank geometry
  localparam int NUM_IDS     = 64;
  localparam int ID_W        = 6;
  localparam int STORE_DEPTH = 1 << ID_W;
  localparam int ID_LIMIT    = (NUM_IDS < STORE_DEPTH) ? NUM_IDS : STORE_DEPTH;
  localparam int LIM_W       = ID_W + 1;

  // Stream widths
  localparam int CMD_W = 2;
  localparam int ST_W  = 2;
  localparam int IN_W  = 8;
  localparam int OUT_W = 8;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOCK   = 2'd2,
    CMD_UNLOCK = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BUSY      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Classified operation as seen by the back end
  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_LOCK   = 3'd2,
    OP_UNLOCK = 3'd3,
    OP_BAD    = 3'd4
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] id;
  } entry_t;

endpackage

>>> sv/mila_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mila_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mila_front.sv
// Front end: accepts commands, classifies them and queues them for the back end.
module mila_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mila_pkg::IN_W-1:0]  s_tdata,   // cmd[1:0], mutex_id[7:2]
  output logic                       q_valid,
  output mila_pkg::entry_t           q_entry,
  input  logic                       q_pop
);

  mila_pkg::entry_t                  slots [mila_pkg::QDEPTH];
  logic [mila_pkg::QPTR_W-1:0]       wr_ptr;
  logic [mila_pkg::QPTR_W-1:0]       rd_ptr;
  logic [mila_pkg::QCNT_W-1:0]       count;
  mila_pkg::cmd_t                    cmd;
  logic [mila_pkg::ID_W-1:0]         id;
  logic                              usable;
  mila_pkg::entry_t                  classified;
  logic                              push;

  // Classify the incoming command
  always_comb begin
    cmd    = mila_pkg::cmd_t'(s_tdata[mila_pkg::CMD_W-1:0]);
    id     = s_tdata[mila_pkg::CMD_W +: mila_pkg::ID_W];
    usable = (id != '0) &&
             ({1'b0, id} < mila_pkg::LIM_W'(mila_pkg::ID_LIMIT));
    classified.id = id;
    unique case (cmd)
      mila_pkg::CMD_ALLOC:  classified.op = mila_pkg::OP_ALLOC;
      mila_pkg::CMD_FREE:   classified.op = usable ? mila_pkg::OP_FREE   : mila_pkg::OP_BAD;
      mila_pkg::CMD_LOCK:   classified.op = usable ? mila_pkg::OP_LOCK   : mila_pkg::OP_BAD;
      mila_pkg::CMD_UNLOCK: classified.op = usable ? mila_pkg::OP_UNLOCK : mila_pkg::OP_BAD;
      default:              classified.op = mila_pkg::OP_BAD;
    endcase
  end

  assign s_tready = (count != mila_pkg::QCNT_W'(mila_pkg::QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_entry  = slots[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= classified;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == mila_pkg::QPTR_W'(mila_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop && q_valid) begin
        rd_ptr <= (rd_ptr == mila_pkg::QPTR_W'(mila_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + mila_pkg::QCNT_W'(push) - mila_pkg::QCNT_W'(q_pop && q_valid);
    end
  end

endmodule

>>> sv/mila_back.sv
// Back end: executes queued commands on the held/lock bits and the allocation list.
module mila_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  mila_pkg::entry_t           q_entry,
  output logic                       q_pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mila_pkg::OUT_W-1:0] m_tdata    // status[1:0], granted_id[7:2]
);

  localparam int IW = mila_pkg::ID_W;

  typedef enum logic [1:0] {
    S_RUN,
    S_LINK,
    S_UNLINK
  } state_t;

  typedef struct packed {
    logic          hit;
    logic [IW-1:0] idx;
  } found_t;

  state_t                            state;
  logic [mila_pkg::STORE_DEPTH-1:0]  held;
  logic [mila_pkg::STORE_DEPTH-1:0]  lock;
  logic [IW-1:0]                     head_id;
  logic [IW-1:0]                     tail_id;
  logic [IW-1:0]                     cur_id;
  logic [IW-1:0]                     link_tail;

  logic                              slot_free;
  logic [IW:0]                       tail_inc;
  logic [IW-1:0]                     start_id;
  found_t                            srch;
  logic [IW-1:0]                     p_id;
  logic [IW-1:0]                     n_id;
  logic [IW-1:0]                     rd_addr;
  logic                              prev_we;
  logic [IW-1:0]                     prev_waddr;
  logic [IW-1:0]                     prev_wdata;
  logic                              next_we;
  logic [IW-1:0]                     next_waddr;
  logic [IW-1:0]                     next_wdata;

  // Round-robin search: lowest free nonzero id at or above start, else lowest free nonzero id
  function automatic found_t find_free(input logic [mila_pkg::STORE_DEPTH-1:0] held_v,
                                       input logic [IW-1:0] start);
    found_t hi;
    found_t any;
    hi  = '0;
    any = '0;
    for (int i = mila_pkg::STORE_DEPTH - 1; i >= 1; i--) begin
      if (i < mila_pkg::ID_LIMIT && !held_v[i]) begin
        any.hit = 1'b1;
        any.idx = IW'(i);
        if (IW'(i) >= start) begin
          hi.hit = 1'b1;
          hi.idx = IW'(i);
        end
      end
    end
    return hi.hit ? hi : any;
  endfunction

  // Link memories
  mila_ram #(.WIDTH(IW), .DEPTH(mila_pkg::STORE_DEPTH)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (rd_addr),
    .rdata (p_id)
  );

  mila_ram #(.WIDTH(IW), .DEPTH(mila_pkg::STORE_DEPTH)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (rd_addr),
    .rdata (n_id)
  );

  // Search, queue pop and link writes
  always_comb begin
    slot_free  = !m_tvalid || m_tready;
    tail_inc   = {1'b0, tail_id} + (IW + 1)'(1);
    start_id   = (tail_inc >= mila_pkg::LIM_W'(mila_pkg::ID_LIMIT)) ? IW'(1) : tail_inc[IW-1:0];
    srch       = find_free(held, start_id);
    rd_addr    = q_entry.id;
    q_pop      = 1'b0;
    prev_we    = 1'b0;
    prev_waddr = srch.idx;
    prev_wdata = tail_id;
    next_we    = 1'b0;
    next_waddr = srch.idx;
    next_wdata = '0;
    unique case (state)
      S_RUN: begin
        if (q_valid && slot_free) begin
          q_pop = 1'b1;
          if (q_entry.op == mila_pkg::OP_ALLOC && srch.hit) begin
            prev_we = 1'b1;
            next_we = 1'b1;
          end
        end
      end
      S_LINK: begin
        next_we    = 1'b1;
        next_waddr = link_tail;
        next_wdata = cur_id;
      end
      S_UNLINK: begin
        if (p_id != '0) begin
          next_we    = 1'b1;
          next_waddr = p_id;
          next_wdata = n_id;
        end
        if (n_id != '0) begin
          prev_we    = 1'b1;
          prev_waddr = n_id;
          prev_wdata = p_id;
        end
      end
      default: ;
    endcase
  end

  // Sequencer, bit state, list ends and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_RUN;
      held     <= '0;
      lock     <= '0;
      head_id  <= '0;
      tail_id  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_RUN: begin
          if (q_valid && slot_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {IW'(0), mila_pkg::ST_OK};
            unique case (q_entry.op)
              mila_pkg::OP_ALLOC: begin
                if (srch.hit) begin
                  held[srch.idx] <= 1'b1;
                  lock[srch.idx] <= 1'b0;
                  tail_id        <= srch.idx;
                  m_tdata        <= {srch.idx, mila_pkg::ST_OK};
                  if (tail_id == '0) begin
                    head_id <= srch.idx;
                  end else begin
                    link_tail <= tail_id;
                    cur_id    <= srch.idx;
                    state     <= S_LINK;
                  end
                end else begin
                  m_tdata <= {IW'(0), mila_pkg::ST_FULL};
                end
              end
              mila_pkg::OP_FREE: begin
                if (held[q_entry.id]) begin
                  // Result comes after the links are read
                  m_tvalid <= 1'b0;
                  cur_id   <= q_entry.id;
                  state    <= S_UNLINK;
                end else begin
                  lock[q_entry.id] <= 1'b0;
                  m_tdata          <= {IW'(0), mila_pkg::ST_NOT_FOUND};
                end
              end
              mila_pkg::OP_LOCK: begin
                if (lock[q_entry.id]) begin
                  m_tdata <= {IW'(0), mila_pkg::ST_BUSY};
                end else begin
                  lock[q_entry.id] <= 1'b1;
                end
              end
              mila_pkg::OP_UNLOCK: begin
                lock[q_entry.id] <= 1'b0;
              end
              default: begin
                m_tdata <= {IW'(0), mila_pkg::ST_NOT_FOUND};
              end
            endcase
          end
        end
        S_LINK: begin
          state <= S_RUN;
        end
        S_UNLINK: begin
          held[cur_id] <= 1'b0;
          if (p_id == '0) begin
            head_id <= n_id;
          end
          if (n_id == '0) begin
            tail_id <= p_id;
          end
          m_tvalid <= 1'b1;
          m_tdata  <= {IW'(0), mila_pkg::ST_OK};
          state    <= S_RUN;
        end
        default: begin
          state <= S_RUN;
        end
      endcase
    end
  end

  // List ends are empty together
  a_ends_empty: assert property (@(posedge clk) disable iff (rst)
    (head_id == '0) == (tail_id == '0))
    else $error("head and tail disagree on empty list");

  // Identifier zero is never held
  a_zero_free: assert property (@(posedge clk) disable iff (rst)
    !held[0])
    else $error("identifier zero marked held");

  // A granted identifier stays held while its result waits
  a_grant_held: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[mila_pkg::ST_W +: IW] != '0) |-> held[m_tdata[mila_pkg::ST_W +: IW]])
    else $error("granted identifier not held");

  // Tail link write only follows an allocate
  a_link_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |-> ($past(state) == S_RUN && !m_tvalid == 1'b0 || $past(state) == S_RUN))
    else $error("link state entered out of order");

endmodule

>>> sv/mutex_id_allocator_lock_bank.sv
// Mutex identifier bank: round-robin allocate, free, test-and-set lock, unlock.
// A command passes the front queue register and then the result register; a free of a
//   held identifier also passes the unlink state before the result register.
// Throughput: lock, unlock and rejected commands 1 per cycle while results are taken;
//   allocate (non-empty list) and free (held id) hold the back end in a link state.
// Reset (rst, synchronous): clears held and lock bits, list ends, queue and result;
//   the link memories are not cleared and need no clearing pass.
module mutex_id_allocator_lock_bank (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mila_pkg::IN_W-1:0]  s_tdata,   // cmd[1:0], mutex_id[7:2]
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mila_pkg::OUT_W-1:0] m_tdata    // status[1:0], granted_id[7:2]
);

  logic             q_valid;
  logic             q_pop;
  mila_pkg::entry_t q_entry;

  mila_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop)
  );

  mila_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
